// ----- hdl/mkt_pkg.sv -----
// ----------------------------------------------------------------------------
// Morse keyer package
// Shared widths, register indexes, item codes, controller commands and the
// Morse symbol table.
// ----------------------------------------------------------------------------
package mkt_pkg;

    localparam int DUR_W  = 16;
    localparam int FREQ_W = 15;
    localparam int TOP_W  = 16;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 3;

    localparam logic [IDX_W-1:0] CFG_DOT    = 3'd0;
    localparam logic [IDX_W-1:0] CFG_DASH   = 3'd1;
    localparam logic [IDX_W-1:0] CFG_LGAP   = 3'd2;
    localparam logic [IDX_W-1:0] CFG_WGAP   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_STEP   = 3'd4;
    localparam logic [IDX_W-1:0] CFG_FMIN   = 3'd5;
    localparam logic [IDX_W-1:0] CFG_FMAX   = 3'd6;

    localparam logic [DUR_W-1:0]  RST_DOT   = 16'd100;
    localparam logic [DUR_W-1:0]  RST_DASH  = 16'd300;
    localparam logic [DUR_W-1:0]  RST_LGAP  = 16'd700;
    localparam logic [DUR_W-1:0]  RST_WGAP  = 16'd1400;
    localparam logic [FREQ_W-1:0] RST_STEP  = 15'd100;
    localparam logic [FREQ_W-1:0] RST_FMIN  = 15'd500;
    localparam logic [FREQ_W-1:0] RST_FMAX  = 15'd2000;
    localparam logic [FREQ_W-1:0] RST_TONE  = 15'd1000;

    localparam logic [1:0] ACT_CHAR = 2'd0;
    localparam logic [1:0] ACT_UP   = 2'd1;
    localparam logic [1:0] ACT_DOWN = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_LOWD  = 8'h64;
    localparam logic [7:0] CH_LOWL  = 8'h6C;

    typedef enum logic [2:0] {
        K_NONE,
        K_UP,
        K_DOWN,
        K_HOLD_ON,
        K_HOLD_OFF,
        K_SPACE,
        K_CODE,
        K_OTHER
    } t_kind;

    typedef enum logic [2:0] {
        SEL_ON,
        SEL_OFF,
        SEL_HOLD,
        SEL_LGAP,
        SEL_WGAP
    } t_sel;

    typedef struct packed {
        logic load;
        logic tone_step;
        logic div_start;
        logic drive_set;
        logic drive_clr;
        logic sym_adv;
        logic emit;
        t_sel sel;
        logic last;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  div_done;
        logic  out_free;
        logic  sym_last;
    } t_sts;

    // Bit i of pat is set when symbol i (sent first at bit 0) is a dash.
    typedef struct packed {
        logic [2:0] len;
        logic [4:0] pat;
    } t_morse;

    localparam t_morse LETTERS [26] = '{
        '{3'd2, 5'b00010}, '{3'd4, 5'b00001}, '{3'd4, 5'b00101}, '{3'd3, 5'b00001},
        '{3'd1, 5'b00000}, '{3'd4, 5'b00100}, '{3'd3, 5'b00011}, '{3'd4, 5'b00000},
        '{3'd2, 5'b00000}, '{3'd4, 5'b01110}, '{3'd3, 5'b00101}, '{3'd4, 5'b00010},
        '{3'd2, 5'b00011}, '{3'd2, 5'b00001}, '{3'd3, 5'b00111}, '{3'd4, 5'b00110},
        '{3'd4, 5'b01011}, '{3'd3, 5'b00010}, '{3'd3, 5'b00000}, '{3'd1, 5'b00001},
        '{3'd3, 5'b00100}, '{3'd4, 5'b01000}, '{3'd3, 5'b00110}, '{3'd4, 5'b01001},
        '{3'd4, 5'b01101}, '{3'd4, 5'b00011}
    };

    localparam t_morse DIGITS [10] = '{
        '{3'd5, 5'b11111}, '{3'd5, 5'b11110}, '{3'd5, 5'b11100}, '{3'd5, 5'b11000},
        '{3'd5, 5'b10000}, '{3'd5, 5'b00000}, '{3'd5, 5'b00001}, '{3'd5, 5'b00011},
        '{3'd5, 5'b00111}, '{3'd5, 5'b01111}
    };

    function automatic t_morse morse_lookup(input logic [7:0] ch);
        logic [7:0] off_l;
        logic [7:0] off_d;
        t_morse     m;
        off_l = ch - CH_A;
        off_d = ch - CH_ZERO;
        m     = '{3'd1, 5'b00000};
        if (ch >= CH_A && ch <= CH_Z) begin
            m = LETTERS[off_l[4:0]];
        end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
            m = DIGITS[off_d[3:0]];
        end
        return m;
    endfunction

    function automatic t_kind decode_kind(input logic [1:0] act, input logic [7:0] ch);
        t_kind k;
        k = K_NONE;
        if (act == ACT_UP) begin
            k = K_UP;
        end else if (act == ACT_DOWN) begin
            k = K_DOWN;
        end else if (act == ACT_CHAR) begin
            if (ch == CH_NUL) begin
                k = K_NONE;
            end else if (ch == CH_LOWL) begin
                k = K_HOLD_ON;
            end else if (ch == CH_LOWD) begin
                k = K_HOLD_OFF;
            end else if (ch == CH_SPACE) begin
                k = K_SPACE;
            end else if ((ch >= CH_A && ch <= CH_Z) || (ch >= CH_ZERO && ch <= CH_NINE)) begin
                k = K_CODE;
            end else begin
                k = K_OTHER;
            end
        end
        return k;
    endfunction

endpackage

// ----- hdl/mkt_ifs.sv -----
// ----------------------------------------------------------------------------
// Morse keyer channels
// Input item channel and result item channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mkt_in_if import mkt_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] char_code;

    modport source (output valid, output action, output char_code, input ready);
    modport sink   (input valid, input action, input char_code, output ready);
endinterface

interface mkt_out_if import mkt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             drive_on;
    logic [DUR_W-1:0] duration_ms;
    logic [TOP_W-1:0] tone_top;
    logic             last;

    modport source (output valid, output drive_on, output duration_ms, output tone_top,
                    output last, input ready);
    modport sink   (input valid, input drive_on, input duration_ms, input tone_top,
                    input last, output ready);
endinterface

// ----- hdl/mkt_div.sv -----
// ----------------------------------------------------------------------------
// Morse keyer tone divider
// Restoring divider of a fixed dividend by the tone frequency, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
module mkt_div import mkt_pkg::*; #(
    parameter int DVD = 2000000
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [FREQ_W-1:0]           i_divisor,
    output logic                        o_done,
    output logic [$clog2(DVD+1)-1:0]    o_quot
);

    localparam int NW = $clog2(DVD + 1);
    localparam int CW = $clog2(NW + 1);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [NW-1:0]     r_dvd;
    logic [NW-1:0]     r_quot;
    logic [FREQ_W-1:0] r_rem;
    logic [FREQ_W-1:0] r_dsr;

    logic [FREQ_W:0]   n_trial;
    logic [FREQ_W:0]   n_diff;
    logic              n_ge;
    logic [FREQ_W-1:0] n_rem;

    always_comb begin
        n_trial = {r_rem, r_dvd[NW-1]};
        n_diff  = n_trial - {1'b0, r_dsr};
        n_ge    = (n_trial >= {1'b0, r_dsr});
        n_rem   = n_ge ? n_diff[FREQ_W-1:0] : n_trial[FREQ_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd  <= NW'(DVD);
            r_rem  <= '0;
            r_quot <= '0;
            r_dsr  <= i_divisor;
        end else if (r_busy) begin
            r_dvd  <= {r_dvd[NW-2:0], 1'b0};
            r_rem  <= n_rem;
            r_quot <= {r_quot[NW-2:0], n_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ----- hdl/mkt_dpath.sv -----
// ----------------------------------------------------------------------------
// Morse keyer datapath
// Configuration registers, tone and drive state, symbol tracking, tone top
// computation and the result output register.
// ----------------------------------------------------------------------------
module mkt_dpath import mkt_pkg::*; #(
    parameter int TIMER_CLOCK_NUM = 2000000
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic [1:0]       i_action,
    input  logic [7:0]       i_char_code,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    mkt_out_if.source        o_out
);

    localparam int NW = $clog2(TIMER_CLOCK_NUM + 1);
    localparam int QW = (NW > TOP_W + 1) ? NW : TOP_W + 1;

    logic [DUR_W-1:0]  r_dot;
    logic [DUR_W-1:0]  r_dash;
    logic [DUR_W-1:0]  r_lgap;
    logic [DUR_W-1:0]  r_wgap;
    logic [FREQ_W-1:0] r_step;
    logic [FREQ_W-1:0] r_fmin;
    logic [FREQ_W-1:0] r_fmax;

    logic [FREQ_W-1:0] r_tone;
    logic              r_level;
    logic [TOP_W-1:0]  r_top;
    logic [1:0]        r_act;
    t_kind             r_kind;
    logic [2:0]        r_sym_len;
    logic [4:0]        r_sym_pat;
    logic [2:0]        r_sym_idx;

    logic              r_out_valid;
    logic              r_out_drive;
    logic [DUR_W-1:0]  r_out_dur;
    logic [TOP_W-1:0]  r_out_top;
    logic              r_out_last;

    logic              div_done;
    logic [NW-1:0]     div_quot;
    logic [QW-1:0]     q_ext;
    logic [QW-1:0]     q_m1;
    logic [TOP_W-1:0]  n_top;

    logic [FREQ_W:0]   up_sum;
    logic [FREQ_W-1:0] dn_diff;
    logic [FREQ_W-1:0] n_tone;

    logic              n_drive;
    logic [DUR_W-1:0]  n_dur;
    t_morse            lk;

    mkt_div #(
        .DVD (TIMER_CLOCK_NUM)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.div_start),
        .i_divisor (r_tone),
        .o_done    (div_done),
        .o_quot    (div_quot)
    );

    always_comb begin
        q_ext = QW'(div_quot);
        q_m1  = q_ext - QW'(1);
        if (r_tone == '0) begin
            n_top = '1;
        end else if (q_ext == '0) begin
            n_top = '0;
        end else if (q_m1 > QW'(17'h0FFFF)) begin
            n_top = '1;
        end else begin
            n_top = q_m1[TOP_W-1:0];
        end
    end

    always_comb begin
        up_sum  = {1'b0, r_tone} + {1'b0, r_step};
        dn_diff = r_tone - r_step;
        if (r_act == ACT_UP) begin
            n_tone = (up_sum > {1'b0, r_fmax}) ? r_fmax : up_sum[FREQ_W-1:0];
        end else if (r_tone < r_step || dn_diff < r_fmin) begin
            n_tone = r_fmin;
        end else begin
            n_tone = dn_diff;
        end
    end

    always_comb begin
        unique case (i_cmd.sel)
            SEL_ON: begin
                n_drive = 1'b1;
                n_dur   = r_sym_pat[r_sym_idx] ? r_dash : r_dot;
            end
            SEL_OFF: begin
                n_drive = 1'b0;
                n_dur   = r_dot;
            end
            SEL_HOLD: begin
                n_drive = r_level;
                n_dur   = '0;
            end
            SEL_LGAP: begin
                n_drive = r_level;
                n_dur   = r_lgap;
            end
            SEL_WGAP: begin
                n_drive = r_level;
                n_dur   = r_wgap;
            end
            default: begin
                n_drive = r_level;
                n_dur   = '0;
            end
        endcase
    end

    assign lk = morse_lookup(i_char_code);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot       <= RST_DOT;
            r_dash      <= RST_DASH;
            r_lgap      <= RST_LGAP;
            r_wgap      <= RST_WGAP;
            r_step      <= RST_STEP;
            r_fmin      <= RST_FMIN;
            r_fmax      <= RST_FMAX;
            r_tone      <= RST_TONE;
            r_level     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_DOT:  r_dot  <= i_cfg_data;
                    CFG_DASH: r_dash <= i_cfg_data;
                    CFG_LGAP: r_lgap <= i_cfg_data;
                    CFG_WGAP: r_wgap <= i_cfg_data;
                    CFG_STEP: r_step <= i_cfg_data[FREQ_W-1:0];
                    CFG_FMIN: r_fmin <= i_cfg_data[FREQ_W-1:0];
                    CFG_FMAX: r_fmax <= i_cfg_data[FREQ_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.tone_step) begin
                r_tone <= n_tone;
            end
            if (i_cmd.drive_set) begin
                r_level <= 1'b1;
            end else if (i_cmd.drive_clr) begin
                r_level <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_done) begin
            r_top <= n_top;
        end
        if (i_cmd.load) begin
            r_act     <= i_action;
            r_kind    <= decode_kind(i_action, i_char_code);
            r_sym_len <= lk.len;
            r_sym_pat <= lk.pat;
            r_sym_idx <= '0;
        end else if (i_cmd.sym_adv) begin
            r_sym_idx <= r_sym_idx + 3'd1;
        end
        if (i_cmd.emit) begin
            r_out_drive <= n_drive;
            r_out_dur   <= n_dur;
            r_out_top   <= r_top;
            r_out_last  <= i_cmd.last;
        end
    end

    always_comb begin
        o_sts.kind     = r_kind;
        o_sts.div_done = div_done;
        o_sts.out_free = !r_out_valid || o_out.ready;
        o_sts.sym_last = (r_sym_idx == r_sym_len - 3'd1);
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.drive_on    = r_out_drive;
    assign o_out.duration_ms = r_out_dur;
    assign o_out.tone_top    = r_out_top;
    assign o_out.last        = r_out_last;

endmodule

// ----- hdl/mkt_ctrl.sv -----
// ----------------------------------------------------------------------------
// Morse keyer controller
// Sequences decode, tone update and the segments of each item.
// ----------------------------------------------------------------------------
module mkt_ctrl import mkt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_INIT_DIV,
        S_INIT_WAIT,
        S_IDLE,
        S_DECODE,
        S_STEP_DIV,
        S_STEP_WAIT,
        S_HOLD,
        S_SPACE,
        S_SYM_ON,
        S_SYM_OFF,
        S_LGAP,
        S_WGAP
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd     = '0;
        o_cmd.sel = SEL_HOLD;
        n_state   = r_state;
        unique case (r_state)
            S_INIT_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_INIT_WAIT;
            end
            S_INIT_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.kind)
                    K_NONE: n_state = S_IDLE;
                    K_UP, K_DOWN: begin
                        o_cmd.tone_step = 1'b1;
                        n_state         = S_STEP_DIV;
                    end
                    K_HOLD_ON: begin
                        o_cmd.drive_set = 1'b1;
                        n_state         = S_HOLD;
                    end
                    K_HOLD_OFF: begin
                        o_cmd.drive_clr = 1'b1;
                        n_state         = S_HOLD;
                    end
                    K_SPACE: begin
                        o_cmd.drive_clr = 1'b1;
                        n_state         = S_SPACE;
                    end
                    K_CODE:  n_state = S_SYM_ON;
                    K_OTHER: n_state = S_LGAP;
                    default: n_state = S_IDLE;
                endcase
            end
            S_STEP_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_STEP_WAIT;
            end
            S_STEP_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SEL_HOLD;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_SPACE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SEL_OFF;
                    n_state    = S_LGAP;
                end
            end
            S_SYM_ON: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.sel       = SEL_ON;
                    o_cmd.drive_set = 1'b1;
                    n_state         = S_SYM_OFF;
                end
            end
            S_SYM_OFF: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.sel       = SEL_OFF;
                    o_cmd.drive_clr = 1'b1;
                    o_cmd.sym_adv   = 1'b1;
                    n_state         = i_sts.sym_last ? S_LGAP : S_SYM_ON;
                end
            end
            S_LGAP: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SEL_LGAP;
                    n_state    = S_WGAP;
                end
            end
            S_WGAP: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SEL_WGAP;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT_DIV;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ----- hdl/morse_keyer_with_tone_step_core.sv -----
// ----------------------------------------------------------------------------
// Morse keyer with stepped tone
// Keys characters into on and off segments and steps the buzzer tone.
// ----------------------------------------------------------------------------
// Each accepted item is a received character or a tone button event. A keyed
// character is decoded in the cycle after acceptance and then sends one result
// per cycle while the sink takes them, up to twelve results for a digit; the
// next item is accepted once the final result is in the output register. A
// button event updates the tone and recomputes the PWM top value with a serial
// divider that yields one quotient bit per cycle. After reset the same divider
// computes the initial top value, and no item is accepted until it is done;
// configuration writes are taken at any time.
module morse_keyer_with_tone_step_core import mkt_pkg::*; #(
    parameter int TIMER_CLOCK_NUM = 2000000
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    mkt_in_if.sink           i_in,
    mkt_out_if.source        o_out
);

    t_cmd cmd;
    t_sts sts;

    mkt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mkt_dpath #(
        .TIMER_CLOCK_NUM (TIMER_CLOCK_NUM)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_action    (i_in.action),
        .i_char_code (i_in.char_code),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out       (o_out)
    );

endmodule
